FILE: design/btbp_pkg.sv
// Shared types and constants for the truncated-block bit packer.
// No dependencies; every other design file refers to this package by scoped names.
package btbp_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;
    localparam int BYTE_W  = 8;

    // Request function codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    // Smallest block size after halving, and index of the block that takes the rest
    localparam int         MIN_BLOCK  = 2;
    localparam logic [1:0] LAST_BLOCK = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
        logic last;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic cnt_nz;
        logic cnt_ge8;
        logic cnt_ge16;
        logic out_free;
    } status_t;

    // First packed bit sits in bit 0 of the stream buffer and goes to bit 7 of the byte
    function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

FILE: design/btbp_item_if.sv
// Request channel of the bit packer: valid/ready plus the request fields.
// Depends on btbp_pkg for field widths.
interface btbp_item_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [btbp_pkg::VALUE_W-1:0]  value;
    logic [btbp_pkg::COUNT_W-1:0]  bit_count;
    logic [btbp_pkg::COUNT_W-1:0]  first_block;

    modport source (output valid, func, value, bit_count, first_block, input ready);
    modport sink   (input valid, func, value, bit_count, first_block, output ready);
endinterface

FILE: design/btbp_byte_if.sv
// Result channel of the bit packer: valid/ready plus one packed byte and its last flag.
// Depends on btbp_pkg for the byte width.
interface btbp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [btbp_pkg::BYTE_W-1:0]  out_byte;
    logic                         last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: design/btbp_ctrl.sv
// Sequencing controller of the bit packer: accepts requests, steps blocks, drains bytes.
// Depends on btbp_pkg (cmd_t, status_t, function codes) and btbp_item_if.
module btbp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    btbp_item_if.sink           item,
    input  btbp_pkg::status_t   status,
    output btbp_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid && ready_reg)
                begin
                    if (item.func == btbp_pkg::FUNC_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (!status.done)
                begin
                    cmd.step = 1'b1;
                end
                else if (status.cnt_ge8)
                begin
                    if (status.out_free)
                    begin
                        cmd.pop  = 1'b1;
                        cmd.last = !status.cnt_ge16;
                        if (!status.cnt_ge16)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    // value produced no full byte: nothing to emit
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (!status.cnt_nz)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign item.ready = ready_reg;

`ifndef NO_ASSERTIONS
    // Between requests the value is fully encoded and no whole byte is left behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (status.done && !status.cnt_ge8))
        else $error("btbp_ctrl: idle with pending work");

    // A flush only ever sees a partial byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> !status.cnt_ge8)
        else $error("btbp_ctrl: flush with a full byte pending");
`endif

endmodule

FILE: design/btbp_dp.sv
// Datapath of the bit packer: value and block registers, block step unit,
// stream buffer and the output byte register. Depends on btbp_pkg and both channel interfaces.
module btbp_dp
#(
    parameter int MAX_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    btbp_item_if.sink           item,
    btbp_byte_if.source         result,
    input  btbp_pkg::cmd_t      cmd,
    output btbp_pkg::status_t   status
);

    localparam int CW  = $clog2(MAX_BITS + 1);
    localparam int SW  = MAX_BITS + 10;
    localparam int SCW = $clog2(SW + 1);
    localparam int VW  = (MAX_BITS > btbp_pkg::VALUE_W) ? MAX_BITS : btbp_pkg::VALUE_W;

    function automatic logic [MAX_BITS-1:0] low_mask(input logic [CW-1:0] k);
        return ~({MAX_BITS{1'b1}} << k);
    endfunction

    logic [MAX_BITS-1:0] rem_reg;
    logic [MAX_BITS-1:0] rem_next;
    logic [CW-1:0]       left_reg;
    logic [CW-1:0]       left_next;
    logic [CW-1:0]       blk_reg;
    logic [CW-1:0]       blk_next;
    logic [1:0]          blkidx_reg;
    logic [1:0]          blkidx_next;
    logic [SW-1:0]       buf_reg;
    logic [SW-1:0]       buf_next;
    logic [SCW-1:0]      cnt_reg;
    logic [SCW-1:0]      cnt_next;

    logic                        out_valid_reg;
    logic [btbp_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;

    // request decode
    logic [CW-1:0]       n_in;
    logic [CW-1:0]       fb_in;
    logic [VW-1:0]       v_wide;

    // block step
    logic [CW-1:0]       eff_blk;
    logic [CW-1:0]       tw;
    logic [MAX_BITS-1:0] chunk;
    logic [MAX_BITS-1:0] lb_vec;
    logic                lb;
    logic [MAX_BITS-1:0] rest;
    logic [CW-1:0]       rest_len;
    logic                more;
    logic                same;
    logic [SW-1:0]       chunk_ext;
    logic [CW-1:0]       blk_half;

    always_comb
    begin
        if (item.bit_count == '0)
        begin
            n_in = CW'(1);
        end
        else if (int'(item.bit_count) > MAX_BITS)
        begin
            n_in = CW'(MAX_BITS);
        end
        else
        begin
            n_in = CW'(item.bit_count);
        end

        if ((item.first_block == '0) || (int'(item.first_block) > int'(n_in)))
        begin
            fb_in = n_in;
        end
        else
        begin
            fb_in = CW'(item.first_block);
        end

        v_wide = VW'(item.value);
    end

    always_comb
    begin
        eff_blk   = (blkidx_reg == btbp_pkg::LAST_BLOCK) ? left_reg : blk_reg;
        tw        = (eff_blk < left_reg) ? eff_blk : left_reg;
        chunk     = rem_reg & low_mask(tw);
        lb_vec    = rem_reg >> (tw - CW'(1));
        lb        = lb_vec[0];
        rest      = rem_reg >> tw;
        rest_len  = left_reg - tw;
        more      = (rest_len != '0);
        same      = lb ? (rest == low_mask(rest_len)) : (rest == '0);
        // continuation bit lands right after the block, only when bits remain
        chunk_ext = SW'(chunk) | (SW'(more && !same) << tw);
        blk_half  = blk_reg >> 1;
    end

    always_comb
    begin
        rem_next    = rem_reg;
        left_next   = left_reg;
        blk_next    = blk_reg;
        blkidx_next = blkidx_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        if (cmd.load)
        begin
            rem_next    = v_wide[MAX_BITS-1:0] & low_mask(n_in);
            left_next   = n_in;
            blk_next    = fb_in;
            blkidx_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next    = rest;
            left_next   = (more && !same) ? rest_len : '0;
            blk_next    = (blk_half < CW'(btbp_pkg::MIN_BLOCK)) ?
                          CW'(btbp_pkg::MIN_BLOCK) : blk_half;
            blkidx_next = (blkidx_reg == btbp_pkg::LAST_BLOCK) ?
                          blkidx_reg : blkidx_reg + 2'd1;
            buf_next    = buf_reg | (chunk_ext << cnt_reg);
            cnt_next    = cnt_reg + SCW'(tw) + SCW'(more);
        end
        else if (cmd.pop)
        begin
            buf_next = buf_reg >> btbp_pkg::BYTE_W;
            cnt_next = cnt_reg - SCW'(btbp_pkg::BYTE_W);
        end
        else if (cmd.flush)
        begin
            buf_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            if (cmd.pop || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        blk_reg    <= blk_next;
        blkidx_reg <= blkidx_next;
        if (cmd.pop || cmd.flush)
        begin
            out_byte_reg <= btbp_pkg::bit_reverse(buf_reg[btbp_pkg::BYTE_W-1:0]);
            out_last_reg <= cmd.flush | cmd.last;
        end
    end

    assign status.done     = (left_reg == '0);
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.cnt_ge8  = (cnt_reg >= SCW'(btbp_pkg::BYTE_W));
    assign status.cnt_ge16 = (cnt_reg >= SCW'(2 * btbp_pkg::BYTE_W));
    assign status.out_free = !out_valid_reg || result.ready;

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;

`ifndef NO_ASSERTIONS
    // The stream buffer never overruns its width
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SCW'(SW))
        else $error("btbp_dp: stream buffer overrun");

    // A block step needs bits left to write
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (left_reg != '0))
        else $error("btbp_dp: block step with no bits left");

    // After the final byte of a value only a partial byte may remain
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && cmd.last) |=> (left_reg == '0) && (cnt_reg < SCW'(btbp_pkg::BYTE_W)))
        else $error("btbp_dp: bits left after the last byte");
`endif

endmodule

FILE: design/block_truncated_bit_packer_top.sv
// Top level of the truncated-block bit packer: controller plus datapath.
// Depends on btbp_pkg, btbp_item_if, btbp_byte_if, btbp_ctrl and btbp_dp.

// An encode request writes the low bit_count bits of value (1 to MAX_BITS; 0 counts as 1,
// larger counts saturate), LSB first, in blocks: the first holds first_block bits (0 or
// anything above the bit count means all of them), each later one half the previous size
// but at least 2, and the fourth takes whatever is left. After each block that leaves bits
// unwritten a continuation bit follows: 0 ends the value when all remaining bits equal the
// last bit written, 1 carries on. Bits pack MSB first into bytes; every full byte is one
// result, and the last result of a request has last set. A flush request emits a pending
// partial byte padded with zeros, and nothing on a byte boundary. Requests are handled one
// at a time: an encode is accepted, then written block by block (1 to 4 blocks) in the shared
// block step unit, then drained byte by byte (0 to 5 bytes) through the single output byte
// register. A flush is accepted, then emits its byte once the output register is free.
// Stalls on the result channel hold the byte drain; the output register lets the next
// request enter while the last byte waits to be taken.
module block_truncated_bit_packer_top
#(
    parameter int MAX_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    btbp_item_if.sink    item,
    btbp_byte_if.source  result
);

    btbp_pkg::cmd_t    cmd;
    btbp_pkg::status_t status;

    // Sequence accept, block steps and byte drain
    btbp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .status (status),
        .cmd    (cmd)
    );

    // Hold the value being encoded, the open stream bits and the output byte
    btbp_dp
    #(
        .MAX_BITS (MAX_BITS)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule
